FILE: hw/rtl/interval_map_table_unit_defines.svh
// Assertion macros shared by the interval map table RTL.
// Used by imt_core.sv; expects clk and rst_n in scope.
`ifndef INTERVAL_MAP_TABLE_UNIT_DEFINES_SVH
`define INTERVAL_MAP_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define IMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define IMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/imt_pkg.sv
// Package for the interval map table: widths, codes, entry and result types.
// No dependencies; imported by imt_core, interval_map_table_unit and the testbench.
`timescale 1ns / 1ps

package imt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int POS_BITS    = 24;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int IPOS_BITS   = POS_BITS + 1;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_PUT    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_START_GT  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    // One stored interval, internal closed-open form
    typedef struct packed {
        logic [IPOS_BITS-1:0]  lo;
        logic [IPOS_BITS-1:0]  hi;
        logic [VALUE_BITS-1:0] data;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Input item
    typedef struct packed {
        logic [2:0]            operation;
        logic [POS_BITS-1:0]   lookup_position;
        logic [POS_BITS-1:0]   range_start;
        logic [POS_BITS-1:0]   range_end;
        logic [VALUE_BITS-1:0] new_value;
        logic [VALUE_BITS-1:0] default_value;
        logic [5:0]            entry_index;
    } req_t;

    // Result item
    typedef struct packed {
        logic [2:0]            status;
        logic                  found;
        logic [VALUE_BITS-1:0] result_value;
        logic [POS_BITS-1:0]   result_start;
        logic [POS_BITS-1:0]   result_end;
        logic [6:0]            entry_total;
    } res_t;

endpackage

FILE: hw/rtl/interval_map_table_unit.sv
// Interval map table: lookup scans the stored entries in order until a hit.
// Put and remove rewrite the table into the spare bank; clear, read entry and
// errors leave the banks unwritten.
// One item in flight; the result register frees the core for the next item.
// rst_n is asynchronous, active low: the table is empty and end_mode is 0.
// Depends on imt_pkg, imt_core and imt_ram.
`timescale 1ns / 1ps

module interval_map_table_unit
    import imt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            operation,
    input  logic [POS_BITS-1:0]   lookup_position,
    input  logic [POS_BITS-1:0]   range_start,
    input  logic [POS_BITS-1:0]   range_end,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [VALUE_BITS-1:0] default_value,
    input  logic [5:0]            entry_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic                  found,
    output logic [VALUE_BITS-1:0] result_value,
    output logic [POS_BITS-1:0]   result_start,
    output logic [POS_BITS-1:0]   result_end,
    output logic [6:0]            entry_total
);

    logic [1:0]            end_mode_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;
    req_t                  req;
    res_t                  res;
    logic                  res_valid;
    logic                  res_ready;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [ENTRY_BITS-1:0] rd_data_a;
    logic [ENTRY_BITS-1:0] rd_data_b;
    logic                  we_a;
    logic                  we_b;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;

    assign req = '{operation: operation, lookup_position: lookup_position,
                   range_start: range_start, range_end: range_end,
                   new_value: new_value, default_value: default_value,
                   entry_index: entry_index};

    // Mode register, always ready for a transfer
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_mode_reg <= '0;
        end
        else if (cfg_valid)
        begin
            end_mode_reg <= cfg_data;
        end
    end

    // Result register
    assign res_ready = !out_valid_reg || out_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign found        = out_reg.found;
    assign result_value = out_reg.result_value;
    assign result_start = out_reg.result_start;
    assign result_end   = out_reg.result_end;
    assign entry_total  = out_reg.entry_total;

    imt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .end_mode  (end_mode_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_addr   (rd_addr),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .we_a      (we_a),
        .we_b      (we_b),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Ping-pong entry banks
    imt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ENTRIES)) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data_a)
    );

    imt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ENTRIES)) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data_b)
    );

endmodule

FILE: hw/rtl/imt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module imt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/imt_core.sv
// Sequencer of the interval map table: scans, rewrites and reads the entry banks.
// Depends on imt_pkg and interval_map_table_unit_defines.svh.
`timescale 1ns / 1ps
`include "interval_map_table_unit_defines.svh"

module imt_core
    import imt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  req_t                req,
    input  logic [1:0]          end_mode,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res,
    output logic [IDX_BITS-1:0] rd_addr,
    input  logic [ENTRY_BITS-1:0] rd_data_a,
    input  logic [ENTRY_BITS-1:0] rd_data_b,
    output logic                we_a,
    output logic                we_b,
    output logic [IDX_BITS-1:0] wr_addr,
    output logic [ENTRY_BITS-1:0] wr_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_READ_RD,
        S_READ_CHK,
        S_APPLY_RD,
        S_APPLY_GOT,
        S_EMIT,
        S_TAIL,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic                   bank_reg;     // bank holding the live table
    logic [CNT_BITS-1:0]    i_reg;        // scan index
    logic [CNT_BITS-1:0]    n_reg;        // write index into the spare bank
    logic                   is_put_reg;
    logic                   placed_reg;
    logic                   so_reg;
    logic                   ec_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [IPOS_BITS-1:0]   lo_reg;
    logic [IPOS_BITS-1:0]   hi_reg;
    logic [VALUE_BITS-1:0]  nv_reg;
    entry_t                 p0_reg;
    entry_t                 p2_reg;
    logic [2:0]             pend_reg;     // pieces left to emit: left, new, right
    entry_t                 hold_reg;     // last emitted entry, not yet written
    logic                   hold_v_reg;
    logic                   hold_new_reg;
    res_t                   res_reg;

    entry_t                 rd_ent;
    entry_t                 new_ent;
    entry_t                 em_ent;
    logic                   em_valid;
    logic                   em_new;
    logic                   merge_prev;
    logic                   merge_next;
    logic                   wr_en;
    logic [IPOS_BITS-1:0]   lo_in;
    logic [IPOS_BITS-1:0]   hi_in;
    logic                   last_idx;
    state_t                 idle_state;
    res_t                   idle_res;

    assign rd_ent  = entry_t'(bank_reg ? rd_data_b : rd_data_a);
    assign new_ent = '{lo: lo_reg, hi: hi_reg, data: nv_reg};
    assign rd_addr = i_reg[IDX_BITS-1:0];
    assign lo_in   = {1'b0, req.range_start} + IPOS_BITS'(end_mode[1]);
    assign hi_in   = {1'b0, req.range_end} + IPOS_BITS'(end_mode[0]);
    assign last_idx = (i_reg + CNT_BITS'(1)) >= count_reg;

    // Decode an incoming transfer: first result fields and next state
    always_comb
    begin
        idle_res             = '0;
        idle_res.entry_total = 7'(count_reg);
        idle_state           = S_DONE;
        unique case (req.operation)
            OP_LOOKUP:
            begin
                idle_res.result_value = req.default_value;
                if (count_reg != '0)
                begin
                    idle_state = S_LOOK_RD;
                end
            end
            OP_PUT, OP_REMOVE:
            begin
                if (req.range_start > req.range_end)
                begin
                    idle_res.status = ST_START_GT;
                end
                else if (lo_in >= hi_in)
                begin
                    idle_res.status = ST_EMPTY;
                end
                else if ((8'(count_reg) + ((req.operation == OP_PUT) ?
                          8'd2 : 8'd1)) > 8'(MAX_ENTRIES))
                begin
                    idle_res.status = ST_FULL;
                end
                else
                begin
                    idle_state = S_APPLY_RD;
                end
            end
            OP_CLEAR:
            begin
                idle_res.entry_total = '0;
            end
            OP_READ:
            begin
                if (CNT_BITS'(req.entry_index) < count_reg)
                begin
                    idle_state = S_READ_RD;
                end
                else
                begin
                    idle_res.status = ST_BAD_INDEX;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Choose the piece emitted this cycle
    always_comb
    begin
        em_valid = 1'b0;
        em_new   = 1'b0;
        em_ent   = p2_reg;
        if (state_reg == S_EMIT)
        begin
            em_valid = 1'b1;
            if (pend_reg[0])
            begin
                em_ent = p0_reg;
            end
            else if (pend_reg[1])
            begin
                em_ent = new_ent;
                em_new = 1'b1;
            end
        end
        else if (state_reg == S_TAIL)
        begin
            em_valid = is_put_reg && !placed_reg;
            em_ent   = new_ent;
            em_new   = 1'b1;
        end
    end

    // Merge with equal-valued neighbours, write the held entry otherwise
    assign merge_prev = em_new && hold_v_reg && (hold_reg.hi == lo_reg)
                        && (hold_reg.data == nv_reg);
    assign merge_next = !em_new && hold_v_reg && hold_new_reg
                        && (em_ent.lo == hold_reg.hi) && (em_ent.data == nv_reg);
    assign wr_en = ((em_valid && !merge_prev && !merge_next) || state_reg == S_FLUSH)
                   && hold_v_reg;
    assign we_a    = wr_en && bank_reg;
    assign we_b    = wr_en && !bank_reg;
    assign wr_addr = n_reg[IDX_BITS-1:0];
    assign wr_data = hold_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            bank_reg     <= 1'b0;
            i_reg        <= '0;
            n_reg        <= '0;
            is_put_reg   <= 1'b0;
            placed_reg   <= 1'b0;
            pend_reg     <= '0;
            hold_v_reg   <= 1'b0;
            hold_new_reg <= 1'b0;
            so_reg       <= 1'b0;
            ec_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pos_reg    <= req.lookup_position;
                        lo_reg     <= lo_in;
                        hi_reg     <= hi_in;
                        nv_reg     <= req.new_value;
                        so_reg     <= end_mode[1];
                        ec_reg     <= end_mode[0];
                        is_put_reg <= (req.operation == OP_PUT);
                        i_reg      <= (req.operation == OP_READ) ?
                                      CNT_BITS'(req.entry_index) : '0;
                        n_reg      <= '0;
                        hold_v_reg <= 1'b0;
                        hold_new_reg <= 1'b0;
                        placed_reg <= 1'b0;
                        res_reg    <= idle_res;
                        state_reg  <= idle_state;
                        if (req.operation == OP_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                    end
                end
                S_LOOK_RD:
                begin
                    state_reg <= S_LOOK_CHK;
                end
                S_LOOK_CHK:
                begin
                    if ({1'b0, pos_reg} >= rd_ent.lo && {1'b0, pos_reg} < rd_ent.hi)
                    begin
                        res_reg.found        <= 1'b1;
                        res_reg.result_value <= rd_ent.data;
                        state_reg            <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_BITS'(1);
                        state_reg <= last_idx ? S_DONE : S_LOOK_RD;
                    end
                end
                S_READ_RD:
                begin
                    state_reg <= S_READ_CHK;
                end
                S_READ_CHK:
                begin
                    res_reg.found        <= 1'b1;
                    res_reg.result_value <= rd_ent.data;
                    res_reg.result_start <= POS_BITS'(rd_ent.lo - IPOS_BITS'(so_reg));
                    res_reg.result_end   <= POS_BITS'(rd_ent.hi - IPOS_BITS'(ec_reg));
                    state_reg            <= S_DONE;
                end
                S_APPLY_RD:
                begin
                    state_reg <= (i_reg >= count_reg) ? S_TAIL : S_APPLY_GOT;
                end
                S_APPLY_GOT:
                begin
                    // split the stored entry against the new range
                    if (rd_ent.hi <= lo_reg || rd_ent.lo >= hi_reg)
                    begin
                        p2_reg <= rd_ent;
                        if (rd_ent.lo >= hi_reg && !placed_reg)
                        begin
                            placed_reg <= 1'b1;
                            pend_reg   <= {1'b1, is_put_reg, 1'b0};
                        end
                        else
                        begin
                            pend_reg <= 3'b100;
                        end
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        p0_reg     <= '{lo: rd_ent.lo, hi: lo_reg, data: rd_ent.data};
                        p2_reg     <= '{lo: hi_reg, hi: rd_ent.hi, data: rd_ent.data};
                        placed_reg <= 1'b1;
                        pend_reg   <= {rd_ent.hi > hi_reg, is_put_reg && !placed_reg,
                                       rd_ent.lo < lo_reg};
                        if (!(rd_ent.hi > hi_reg) && !(is_put_reg && !placed_reg)
                            && !(rd_ent.lo < lo_reg))
                        begin
                            i_reg     <= i_reg + CNT_BITS'(1);
                            state_reg <= S_APPLY_RD;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT, S_TAIL:
                begin
                    if (em_valid)
                    begin
                        if (merge_prev)
                        begin
                            hold_reg.hi  <= hi_reg;
                            hold_new_reg <= 1'b1;
                        end
                        else if (merge_next)
                        begin
                            hold_reg.hi  <= em_ent.hi;
                            hold_new_reg <= 1'b0;
                        end
                        else
                        begin
                            hold_reg     <= em_ent;
                            hold_v_reg   <= 1'b1;
                            hold_new_reg <= em_new;
                        end
                    end
                    if (wr_en)
                    begin
                        n_reg <= n_reg + CNT_BITS'(1);
                    end
                    if (state_reg == S_TAIL)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        priority if (pend_reg[0])
                        begin
                            pend_reg[0] <= 1'b0;
                            if (pend_reg[2:1] == 2'b00)
                            begin
                                i_reg     <= i_reg + CNT_BITS'(1);
                                state_reg <= S_APPLY_RD;
                            end
                        end
                        else if (pend_reg[1])
                        begin
                            pend_reg[1] <= 1'b0;
                            if (!pend_reg[2])
                            begin
                                i_reg     <= i_reg + CNT_BITS'(1);
                                state_reg <= S_APPLY_RD;
                            end
                        end
                        else
                        begin
                            pend_reg[2] <= 1'b0;
                            i_reg       <= i_reg + CNT_BITS'(1);
                            state_reg   <= S_APPLY_RD;
                        end
                    end
                end
                S_FLUSH:
                begin
                    count_reg <= n_reg + CNT_BITS'(hold_v_reg);
                    res_reg.entry_total <= 7'(n_reg + CNT_BITS'(hold_v_reg));
                    bank_reg  <= !bank_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `IMT_ASSERT_IMP(a_wr_in_range, wr_en, n_reg < CNT_BITS'(MAX_ENTRIES), "write past table end")
    `IMT_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CNT_BITS'(MAX_ENTRIES), "count above depth")
    `IMT_ASSERT_NXT(a_clear, in_valid && in_ready && req.operation == OP_CLEAR, count_reg == '0, "clear did not empty table")
    `IMT_ASSERT_IMP(a_one_bank_write, 1'b1, !(we_a && we_b), "both banks written")

endmodule

FILE: tb/interval_map_table_unit_tb.sv
// Testbench for interval_map_table_unit: directed table, then random traffic.
// Results are checked against an in-bench interval table model; depends on imt_pkg.
`timescale 1ns / 1ps

module interval_map_table_unit_tb;
    import imt_pkg::*;

    localparam int CLK_HALF  = 10;
    localparam int CYC_LIMIT = 2000000;
    localparam int N_RANDOM  = 405;
    localparam int IDLE_GAP  = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            operation;
    logic [POS_BITS-1:0]   lookup_position;
    logic [POS_BITS-1:0]   range_start;
    logic [POS_BITS-1:0]   range_end;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] default_value;
    logic [5:0]            entry_index;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] result_value;
    logic [POS_BITS-1:0]   result_start;
    logic [POS_BITS-1:0]   result_end;
    logic [6:0]            entry_total;

    interval_map_table_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .lookup_position(lookup_position), .range_start(range_start),
        .range_end(range_end), .new_value(new_value),
        .default_value(default_value), .entry_index(entry_index),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .found(found), .result_value(result_value), .result_start(result_start),
        .result_end(result_end), .entry_total(entry_total)
    );

    // Model state of the interval table
    logic [IPOS_BITS-1:0]  tbl_lo   [MAX_ENTRIES];
    logic [IPOS_BITS-1:0]  tbl_hi   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] tbl_data [MAX_ENTRIES];
    int                    tbl_count;
    logic [1:0]            mode_now;

    res_t pending_results[$];
    int   fail_count;
    int   cycle_count;
    int   result_count;
    int   op_seen[8];
    int   st_seen[8];
    int   in_idle_pct;
    int   out_idle_pct;

    always #CLK_HALF clk = ~clk;

    // Cut [lo,hi) out of the table; on put insert it and merge equal neighbors
    function automatic void cut_range(logic [IPOS_BITS-1:0] lo, logic [IPOS_BITS-1:0] hi,
                                      bit is_put, logic [VALUE_BITS-1:0] v);
        logic [IPOS_BITS-1:0]  nlo[$];
        logic [IPOS_BITS-1:0]  nhi[$];
        logic [VALUE_BITS-1:0] nd[$];
        int  ins;
        bit  placed;
        bit  mprev;
        bit  mnext;
        placed = 0;
        ins = 0;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_hi[i] <= lo || tbl_lo[i] >= hi)
            begin
                if (tbl_lo[i] >= hi && !placed)
                begin
                    ins = nlo.size();
                    placed = 1;
                end
                nlo.push_back(tbl_lo[i]); nhi.push_back(tbl_hi[i]); nd.push_back(tbl_data[i]);
                continue;
            end
            if (tbl_lo[i] < lo)
            begin
                nlo.push_back(tbl_lo[i]); nhi.push_back(lo); nd.push_back(tbl_data[i]);
            end
            if (!placed)
            begin
                ins = nlo.size();
                placed = 1;
            end
            if (tbl_hi[i] > hi)
            begin
                nlo.push_back(hi); nhi.push_back(tbl_hi[i]); nd.push_back(tbl_data[i]);
            end
        end
        if (!placed)
            ins = nlo.size();
        if (is_put)
        begin
            mprev = ins > 0 && nhi[ins-1] == hi - hi + lo && nd[ins-1] == v;
            mnext = ins < nlo.size() && nlo[ins] == hi && nd[ins] == v;
            if (mprev && mnext)
            begin
                nhi[ins-1] = nhi[ins];
                nlo.delete(ins); nhi.delete(ins); nd.delete(ins);
            end
            else if (mprev)
                nhi[ins-1] = hi;
            else if (mnext)
                nlo[ins] = lo;
            else
            begin
                nlo.insert(ins, lo); nhi.insert(ins, hi); nd.insert(ins, v);
            end
        end
        tbl_count = (nlo.size() > MAX_ENTRIES) ? MAX_ENTRIES : nlo.size();
        for (int i = 0; i < tbl_count; i++)
        begin
            tbl_lo[i] = nlo[i]; tbl_hi[i] = nhi[i]; tbl_data[i] = nd[i];
        end
    endfunction

    // Expected result of one request; updates the model table
    function automatic res_t table_step(req_t rq);
        res_t r;
        logic [IPOS_BITS-1:0] lo;
        logic [IPOS_BITS-1:0] hi;
        logic so;
        logic ec;
        int   need;
        r = '0;
        so = mode_now >= 2;
        ec = mode_now == 1 || mode_now == 3;
        case (rq.operation)
            OP_LOOKUP:
            begin
                r.result_value = rq.default_value;
                for (int i = 0; i < tbl_count; i++)
                    if ({1'b0, rq.lookup_position} >= tbl_lo[i] &&
                        {1'b0, rq.lookup_position} < tbl_hi[i])
                    begin
                        r.found = 1;
                        r.result_value = tbl_data[i];
                        break;
                    end
            end
            OP_PUT, OP_REMOVE:
            begin
                lo = {1'b0, rq.range_start} + so;
                hi = {1'b0, rq.range_end} + ec;
                need = (rq.operation == OP_PUT) ? 2 : 1;
                if (rq.range_start > rq.range_end)
                    r.status = ST_START_GT;
                else if (lo >= hi)
                    r.status = ST_EMPTY;
                else if (tbl_count + need > MAX_ENTRIES)
                    r.status = ST_FULL;
                else
                    cut_range(lo, hi, rq.operation == OP_PUT, rq.new_value);
            end
            OP_CLEAR:
                tbl_count = 0;
            OP_READ:
            begin
                if (rq.entry_index < tbl_count)
                begin
                    r.found = 1;
                    r.result_value = tbl_data[rq.entry_index];
                    r.result_start = POS_BITS'(tbl_lo[rq.entry_index] - so);
                    r.result_end   = POS_BITS'(tbl_hi[rq.entry_index] - ec);
                end
                else
                    r.status = ST_BAD_INDEX;
            end
            default: ;
        endcase
        r.entry_total = 7'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // Result checker and output stall generator
    always @(posedge clk)
    begin
        res_t w;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(status), 0);
            else
            begin
                w = pending_results.pop_front();
                st_seen[status]++;
                if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
                if (found !== w.found) report_mismatch("found", 32'(found), 32'(w.found));
                if (result_value !== w.result_value)
                    report_mismatch("result_value", result_value, w.result_value);
                if (result_start !== w.result_start)
                    report_mismatch("result_start", 32'(result_start), 32'(w.result_start));
                if (result_end !== w.result_end)
                    report_mismatch("result_end", 32'(result_end), 32'(w.result_end));
                if (entry_total !== w.entry_total)
                    report_mismatch("entry_total", 32'(entry_total), 32'(w.entry_total));
            end
        end
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
        if (cycle_count > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end

    // Send one request; the model is updated at the accepting edge.
    // Valid stays high after the transfer until the next idle or drain.
    task automatic send_req(req_t rq);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= rq.operation;
        lookup_position <= rq.lookup_position;
        range_start     <= rq.range_start;
        range_end       <= rq.range_end;
        new_value       <= rq.new_value;
        default_value   <= rq.default_value;
        entry_index     <= rq.entry_index;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(table_step(rq));
        op_seen[rq.operation]++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_mode(logic [1:0] m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_now = m;
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t mk(logic [2:0] op, int pos, int rs, int re,
                                logic [31:0] nv, logic [31:0] dv, int idx);
        req_t q;
        q.operation = op;
        q.lookup_position = POS_BITS'(pos);
        q.range_start = POS_BITS'(rs);
        q.range_end = POS_BITS'(re);
        q.new_value = nv;
        q.default_value = dv;
        q.entry_index = 6'(idx);
        return q;
    endfunction

    // Random request, biased to a small position window so intervals overlap
    function automatic req_t rand_req();
        req_t q;
        int   span;
        int   a;
        int   b;
        q.lookup_position = POS_BITS'($urandom);
        q.range_start     = POS_BITS'($urandom);
        q.range_end       = POS_BITS'($urandom);
        q.new_value       = $urandom;
        q.default_value   = $urandom;
        q.entry_index     = 6'($urandom);
        span = ($urandom_range(3) == 0) ? 24'hFFFFFF : 200;
        a = $urandom_range(span);
        b = $urandom_range(span);
        case ($urandom_range(99)) inside
            [0:44]:  q.operation = OP_PUT;
            [45:59]: q.operation = OP_REMOVE;
            [60:74]: q.operation = OP_LOOKUP;
            [75:91]: q.operation = OP_READ;
            [92:93]: q.operation = OP_CLEAR;
            default: q.operation = 3'($urandom_range(7, 5));
        endcase
        if (q.operation == OP_LOOKUP && span != 24'hFFFFFF)
            q.lookup_position = POS_BITS'(a);
        if ((q.operation == OP_PUT || q.operation == OP_REMOVE) && span != 24'hFFFFFF)
        begin
            q.range_start = POS_BITS'(a);
            q.range_end   = ($urandom_range(9) == 0) ? POS_BITS'(b)
                                                     : POS_BITS'(a + $urandom_range(20));
        end
        if (q.operation == OP_PUT && $urandom_range(1))
            q.new_value = 32'($urandom_range(3));
        if (q.operation == OP_READ && $urandom_range(3) != 0)
            q.entry_index = 6'($urandom_range(tbl_count));
        return q;
    endfunction

    // Directed rows: request plus a typed expectation where one is obvious
    typedef struct {
        req_t rq;
        bit   has_want;
        res_t want;
    } row_t;

    row_t dir_rows[$];

    task automatic add_row(req_t rq, bit hw, logic [2:0] st, logic fnd, logic [31:0] v,
                           int cnt);
        row_t r;
        r.rq = rq;
        r.has_want = hw;
        r.want = '0;
        r.want.status = st;
        r.want.found = fnd;
        r.want.result_value = v;
        r.want.entry_total = 7'(cnt);
        dir_rows.push_back(r);
    endtask

    initial
    begin
        res_t pred;
        clk = 0; rst_n = 0;
        cfg_valid = 0; cfg_data = '0; in_valid = 0; out_ready = 0;
        operation = '0; lookup_position = '0; range_start = '0; range_end = '0;
        new_value = '0; default_value = '0; entry_index = '0;
        tbl_count = 0; mode_now = 0; fail_count = 0; cycle_count = 0; result_count = 0;
        in_idle_pct = 0; out_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        add_row(mk(OP_LOOKUP, 5, 0, 0, 0, 32'hDEADBEEF, 0), 1, ST_OK, 0, 32'hDEADBEEF, 0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0), 1, ST_BAD_INDEX, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 9, 3, 1, 0, 0), 1, ST_START_GT, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 7, 7, 1, 0, 0), 1, ST_EMPTY, 0, 0, 0);
        add_row(mk(OP_REMOVE, 0, 8, 2, 0, 0, 0), 1, ST_START_GT, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 0, 16777215, 32'hFFFFFFFF, 0, 0), 1, ST_OK, 0, 0, 1);
        // top position lies just past the closed-open end: a miss
        add_row(mk(OP_LOOKUP, 16777215, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0, 1);
        add_row(mk(OP_PUT, 0, 100, 200, 32'h5, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 200, 300, 32'h5, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 300, 400, 32'h6, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 50, 100, 32'h5, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_REMOVE, 0, 150, 160, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_PUT, 0, 300, 400, 32'h7, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0, 0);
        add_row(mk(OP_READ, 0, 0, 0, 0, 0, 63), 1, ST_BAD_INDEX, 0, 0, 5);
        add_row(mk(OP_LOOKUP, 155, 0, 0, 0, 32'h1234, 0), 0, 0, 0, 0, 0);
        add_row(mk(3'd5, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(3'd7, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
        add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, ST_OK, 0, 0, 0);
        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].rq);
            pred = pending_results[$];
            if (dir_rows[i].has_want && pred !== dir_rows[i].want)
                report_mismatch("directed row model", i, 0);
        end

        // Modes: open-open empty range, closed-closed single point
        write_mode(2);
        send_req(mk(OP_PUT, 0, 10, 11, 1, 0, 0));
        send_req(mk(OP_PUT, 0, 10, 12, 1, 0, 0));
        send_req(mk(OP_PUT, 0, 16777214, 16777215, 2, 0, 0));
        write_mode(1);
        send_req(mk(OP_PUT, 0, 16777215, 16777215, 3, 0, 0));
        write_mode(3);
        send_req(mk(OP_READ, 0, 0, 0, 0, 0, 0));
        send_req(mk(OP_READ, 0, 0, 0, 0, 0, 1));
        write_mode(0);
        send_req(mk(OP_READ, 0, 0, 0, 0, 0, 0));
        // Fill the table to the full limit
        for (int i = 0; i < 66; i++)
            send_req(mk(OP_PUT, 0, 1000 + 4 * i, 1001 + 4 * i, i, 0, 0));
        send_req(mk(OP_REMOVE, 0, 1000, 1000, 0, 0, 0));
        send_req(mk(OP_REMOVE, 0, 1000, 1000, 0, 0, 0));
        send_req(mk(OP_READ, 0, 0, 0, 0, 0, 63));
        send_req(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));

        // Random part in three idling phases, mode changes between them
        for (int ph = 0; ph < 3; ph++)
        begin
            in_idle_pct  = (ph == 0) ? 27 : (ph == 1) ? 71 : 0;
            out_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 27 : 0;
            write_mode(2'($urandom_range(3)));
            for (int n = 0; n < N_RANDOM / 3; n++)
            begin
                send_req(rand_req());
                if (n == 40)
                    drain_results();
            end
        end

        drain_results();
        $display("covered %0d results: ops lookup/put/remove/clear/read %0d/%0d/%0d/%0d/%0d",
                 result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        $display("statuses ok/empty/order/full/index %0d/%0d/%0d/%0d/%0d, all four end modes",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/imt_pkg.sv
hw/rtl/imt_ram.sv
hw/rtl/imt_core.sv
hw/rtl/interval_map_table_unit.sv
tb/interval_map_table_unit_tb.sv
